// ===== hw/rtl/ptlt_pkg.sv =====
package ptlt_pkg;

    // sizes of the translation tables
    localparam int MAX_PAGES       = 256;
    localparam int MAX_FRAMES      = 16;
    localparam int MAX_OFFSET_BITS = 16;

    localparam int PAGE_W     = $clog2(MAX_PAGES);
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int FCNT_W     = FRAME_W + 1;
    localparam int ADDR_W     = 24;
    localparam int PA_W       = 20;
    localparam int OFFB_W     = 5;
    localparam int PAGEB_W    = 4;
    localparam int FRAMEB_W   = 3;
    localparam int FLT_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BITS  = 2'd2;

    // reset values of the configuration registers
    localparam logic [OFFB_W-1:0]   RST_OFFSET_BITS = 5'd8;
    localparam logic [PAGEB_W-1:0]  RST_PAGE_BITS   = 4'd8;
    localparam logic [FRAMEB_W-1:0] RST_FRAME_BITS  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_HIT,
        S_SCAN_FREE,
        S_SCAN_OLD,
        S_EVICT,
        S_COMMIT,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/ptlt_ram.sv =====
module ptlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/page_table_lru_translator_top.sv =====
// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_ready       i_logical_address
// out       output     o_out_valid / i_out_ready     o_physical_address, o_page_fault,
//                                                    o_address_error, o_fault_count
// cfg       input      i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// one word in flight at a time; o_in_ready is high only while the sequencer idles
// out of range: lookup, done; hit: lookup, hit, done (page table ram read is registered)
// fault on free frame k: lookup, free scan of frames 1 .. k, commit, done; eviction:
// free scan, single stamp comparator over frames 1 .. frames-1, evict, commit, done
// synchronous active-low reset clears valid bits, owner bits, stamps and counters;
// the page frame table is not cleared, its entries are read only while valid
// a stalled output holds the sequencer in its last step; cfg writes are always taken
module page_table_lru_translator_top
    import ptlt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ADDR_W-1:0]     i_logical_address,

    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [PA_W-1:0]       o_physical_address,
    output logic                  o_page_fault,
    output logic                  o_address_error,
    output logic [FLT_W-1:0]      o_fault_count,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic [OFFB_W-1:0]   r_offset_bits;
    logic [PAGEB_W-1:0]  r_page_bits;
    logic [FRAMEB_W-1:0] r_frame_bits;

    // sequencer
    t_state r_state;
    t_state n_state;

    // current word
    logic [ADDR_W-1:0]          r_pnum;
    logic [MAX_OFFSET_BITS-1:0] r_off;
    logic [FRAME_W-1:0]         r_fnum;
    logic                       r_fault;
    logic                       r_err;

    // scan unit: one index, one running best
    logic [FCNT_W-1:0]  r_k;
    logic [FRAME_W-1:0] r_best;
    logic [TIME_W-1:0]  r_best_stamp;

    // page and frame tables
    logic [MAX_PAGES-1:0]  r_page_valid;
    logic [MAX_FRAMES-1:0] r_frame_free;
    logic [MAX_FRAMES-1:0] r_owner_set;
    logic [PAGE_W-1:0]     r_frame_owner [MAX_FRAMES];
    logic [TIME_W-1:0]     r_frame_stamp [MAX_FRAMES];
    logic [TIME_W-1:0]     r_access_time;
    logic [FLT_W-1:0]      r_faults_seen;

    // result register
    logic                r_out_valid;
    logic [PA_W-1:0]     r_pa;
    logic                r_out_fault;
    logic                r_out_err;
    logic [FLT_W-1:0]    r_out_count;

    // derived configuration
    logic [OFFB_W-1:0]  w_d;
    logic [PAGEB_W-1:0] w_pb;
    logic [FCNT_W-1:0]  w_frames;
    logic [ADDR_W-1:0]  w_off_full;
    logic [ADDR_W-1:0]  w_pa_full;
    logic [PAGE_W-1:0]  w_page;
    logic [FRAME_W-1:0] w_kidx;
    logic [FRAME_W-1:0] w_ram_rdata;
    logic               w_addr_err;
    logic               w_k_in_range;
    logic               w_out_free;
    logic               w_ram_we;

    assign w_d  = (r_offset_bits > OFFB_W'(MAX_OFFSET_BITS)) ?
                  OFFB_W'(MAX_OFFSET_BITS) : r_offset_bits;
    assign w_pb = (r_page_bits > PAGEB_W'(PAGE_W)) ? PAGEB_W'(PAGE_W) : r_page_bits;

    // frame count: 2^frame_bits, at least 2, at most the table size
    always_comb begin
        w_frames = FCNT_W'(MAX_FRAMES);
        if (r_frame_bits == '0) begin
            w_frames = FCNT_W'(2);
        end else if (r_frame_bits < FRAMEB_W'(FRAME_W)) begin
            w_frames = FCNT_W'(1) << r_frame_bits;
        end
    end

    assign w_off_full   = (ADDR_W'(1) << w_d) - ADDR_W'(1);
    assign w_page       = r_pnum[PAGE_W-1:0];
    assign w_kidx       = r_k[FRAME_W-1:0];
    assign w_addr_err   = (r_pnum >> w_pb) != '0;
    assign w_k_in_range = r_k < w_frames;
    assign w_out_free   = !r_out_valid || i_out_ready;
    // offset never reaches past the shifted frame, so or works as add
    assign w_pa_full    = (ADDR_W'(r_fnum) << w_d) | ADDR_W'(r_off);
    assign w_ram_we     = (r_state == S_COMMIT);

    // page number to frame table
    ptlt_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_PAGES)
    ) u_page_frame (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_page),
        .i_wdata (r_fnum),
        .i_raddr (w_page),
        .o_rdata (w_ram_rdata)
    );

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= RST_OFFSET_BITS;
            r_page_bits   <= RST_PAGE_BITS;
            r_frame_bits  <= RST_FRAME_BITS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[OFFB_W-1:0];
                CFG_PAGE_BITS:   r_page_bits   <= i_cfg_data[PAGEB_W-1:0];
                CFG_FRAME_BITS:  r_frame_bits  <= i_cfg_data[FRAMEB_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (w_addr_err) begin
                    n_state = S_DONE;
                end else if (r_page_valid[w_page]) begin
                    n_state = S_HIT;
                end else begin
                    n_state = S_SCAN_FREE;
                end
            end
            S_HIT: n_state = S_DONE;
            S_SCAN_FREE: begin
                if (!w_k_in_range) begin
                    n_state = S_SCAN_OLD;
                end else if (r_frame_free[w_kidx]) begin
                    n_state = S_COMMIT;
                end
            end
            S_SCAN_OLD: begin
                if (!w_k_in_range) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT:  n_state = S_COMMIT;
            S_COMMIT: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath and tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_valid  <= '0;
            r_frame_free  <= {{(MAX_FRAMES-1){1'b1}}, 1'b0};
            r_owner_set   <= '0;
            r_access_time <= '0;
            r_faults_seen <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_frame_stamp[i] <= '0;
            end
        end else begin
            // in the last step a taken result is replaced by the new one below
            if (i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pnum  <= i_logical_address >> w_d;
                        r_off   <= i_logical_address[MAX_OFFSET_BITS-1:0] &
                                   w_off_full[MAX_OFFSET_BITS-1:0];
                        r_fault <= 1'b0;
                        r_err   <= 1'b0;
                    end
                end
                S_LOOKUP: begin
                    r_k <= FCNT_W'(1);
                    if (w_addr_err) begin
                        r_err <= 1'b1;
                    end else if (!r_page_valid[w_page]) begin
                        r_fault <= 1'b1;
                        if (r_faults_seen != '1) begin
                            r_faults_seen <= r_faults_seen + FLT_W'(1);
                        end
                    end
                end
                S_HIT: r_fnum <= w_ram_rdata;
                S_SCAN_FREE: begin
                    if (!w_k_in_range) begin
                        // no free frame: start oldest stamp search at frame 1
                        r_best       <= FRAME_W'(1);
                        r_best_stamp <= r_frame_stamp[1];
                        r_k          <= FCNT_W'(2);
                    end else if (r_frame_free[w_kidx]) begin
                        r_frame_free[w_kidx] <= 1'b0;
                        r_fnum               <= w_kidx;
                    end else begin
                        r_k <= r_k + FCNT_W'(1);
                    end
                end
                S_SCAN_OLD: begin
                    if (w_k_in_range) begin
                        // strict less keeps the lowest index on ties
                        if (r_frame_stamp[w_kidx] < r_best_stamp) begin
                            r_best       <= w_kidx;
                            r_best_stamp <= r_frame_stamp[w_kidx];
                        end
                        r_k <= r_k + FCNT_W'(1);
                    end
                end
                S_EVICT: begin
                    r_fnum <= r_best;
                    if (r_owner_set[r_best]) begin
                        r_page_valid[r_frame_owner[r_best]] <= 1'b0;
                    end
                end
                S_COMMIT: begin
                    r_page_valid[w_page]  <= 1'b1;
                    r_owner_set[r_fnum]   <= 1'b1;
                    r_frame_owner[r_fnum] <= w_page;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_fault <= r_fault;
                        r_out_err   <= r_err;
                        r_out_count <= r_faults_seen;
                        if (r_err) begin
                            r_pa <= '0;
                        end else begin
                            r_pa <= w_pa_full[PA_W-1:0];
                            // stamp the frame with the advanced time, saturating
                            if (r_access_time != '1) begin
                                r_access_time         <= r_access_time + TIME_W'(1);
                                r_frame_stamp[r_fnum] <= r_access_time + TIME_W'(1);
                            end else begin
                                r_frame_stamp[r_fnum] <= r_access_time;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_physical_address = r_pa;
    assign o_page_fault       = r_out_fault;
    assign o_address_error    = r_out_err;
    assign o_fault_count      = r_out_count;

`ifndef SYNTHESIS
    // frame 0 is reserved and never handed out
    a_frame0_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_free[0] && !r_owner_set[0])
        else $error("frame 0 became free or owned");

    // a result is never both a fault and an address error
    a_fault_xor_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_page_fault && o_address_error))
        else $error("fault and address error together");

    // fault counter moves by at most one per cycle
    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_faults_seen == $past(r_faults_seen) ||
                  r_faults_seen == $past(r_faults_seen) + FLT_W'(1)))
        else $error("fault counter jumped");

    // the oldest stamp scan index never falls below 2; frame 1 is its starting best
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN_OLD |-> r_k >= FCNT_W'(2))
        else $error("oldest scan index below 2");

    // an evicting frame is always within the table and not reserved
    a_evict_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EVICT |-> r_best != '0)
        else $error("eviction picked frame 0");
`endif

endmodule
